FILE: hw/rtl/pidaw_pkg.sv
// Shared types and constants for the PID controller with integral clamp.
// Holds the datapath operation codes and the controller/datapath command and status structs.
`timescale 1ns / 1ps

package pidaw_pkg;

  localparam int STEP_W = 24;
  localparam int Q_FRAC = 16;

  localparam logic [1:0] REG_KP    = 2'd0;
  localparam logic [1:0] REG_KI    = 2'd1;
  localparam logic [1:0] REG_KD    = 2'd2;
  localparam logic [1:0] REG_LIMIT = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_EDT,
    OP_INTEG,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_TERM_D,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: hw/rtl/pid_controller_antiwindup_top.sv
// PID controller with integral clamp: one result per input beat. The derivative comes from
// a one-bit-per-cycle divider, which is skipped when the time step is zero. One item is in
// work at a time; a finished result waits in the output register, and while the output is
// stalled the controller holds in its finish state until the previous result is taken.
// Synchronous reset clears gains, state and the output valid, and sets the windup limit to
// its maximum. Depends on pidaw_pkg, pidaw_ctrl and pidaw_dp.
`timescale 1ns / 1ps

module pid_controller_antiwindup_top #(
  parameter int DATA_WIDTH   = 32,
  parameter int DT_FRAC_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // error_sample, step_time, zero fill
  input  logic [((DATA_WIDTH+pidaw_pkg::STEP_W+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // drive, zero fill
  output logic [((DATA_WIDTH+7)/8)*8-1:0] out_tdata,
  // saturated
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_wdata
);
  import pidaw_pkg::*;

  localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

  dp_cmd_t         cmd;
  dp_status_t      status;
  logic [DATA_WIDTH-1:0] drive;

  pidaw_ctrl #(
    .DIV_STEPS(DATA_WIDTH + 1 + DT_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .status   (status)
  );

  pidaw_dp #(
    .DATA_WIDTH  (DATA_WIDTH),
    .DT_FRAC_BITS(DT_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .error_sample (in_tdata[DATA_WIDTH-1:0]),
    .step_time    (in_tdata[DATA_WIDTH +: STEP_W]),
    .drive        (drive),
    .saturated    (out_tuser),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready)
  );

  assign out_tdata = OUT_W'(drive);

endmodule

FILE: hw/rtl/pidaw_dp.sv
// Datapath of the PID controller: gain registers, state, shared multiplier and bit-serial divider.
// Depends on pidaw_pkg for the command and status types.
`timescale 1ns / 1ps

module pidaw_dp #(
  parameter int DATA_WIDTH   = 32,
  parameter int DT_FRAC_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pidaw_pkg::dp_cmd_t           cmd,
  output pidaw_pkg::dp_status_t        status,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_wdata,
  input  logic [DATA_WIDTH-1:0]        error_sample,
  input  logic [pidaw_pkg::STEP_W-1:0] step_time,
  output logic [DATA_WIDTH-1:0]        drive,
  output logic                         saturated,
  output logic                         out_valid,
  input  logic                         out_ready
);
  import pidaw_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int MW = (DW > STEP_W) ? DW : STEP_W;
  localparam int PW = 2 * MW;
  localparam int NW = DW + 1 + DT_FRAC_BITS;
  localparam int SW = (PW > NW) ? PW : NW;
  localparam logic [SW-1:0] TOP = SW'(1) << (DW - 1);

  function automatic logic [DW:0] sat_mag(input logic [SW-1:0] m, input logic neg);
    logic [SW-1:0] nm;
    nm = ~m + SW'(1);
    if (neg) begin
      if (m > TOP) sat_mag = {1'b1, TOP[DW-1:0]};
      else sat_mag = {1'b0, nm[DW-1:0]};
    end else begin
      if (m > TOP - SW'(1)) sat_mag = {1'b1, ~TOP[DW-1:0]};
      else sat_mag = {1'b0, m[DW-1:0]};
    end
  endfunction

  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
    mag_of = v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  logic [DW-1:0]     kp_r, ki_r, kd_r;
  logic [DW-2:0]     limit_r;
  logic [DW-1:0]     integral_r, last_r, e_r, deriv_r;
  logic [STEP_W-1:0] dt_r;
  logic [PW-1:0]     prod_r;
  logic              prod_neg_r, prod_dt_r;
  logic [DW-1:0]     tp_r, ti_r, td_r;
  logic              flag_r;
  logic [NW-1:0]     q_r;
  logic [STEP_W-1:0] rem_r;
  logic              dneg_r;
  logic [DW-1:0]     drive_r;
  logic              sat_r, out_valid_r;

  logic [MW-1:0]     mul_a, mul_b;
  logic              mul_neg;
  logic [PW-1:0]     shifted;
  logic [DW:0]       term;
  logic [DW:0]       isum;
  logic [DW:0]       lim_pos, lim_neg;
  logic [DW:0]       num;
  logic [DW:0]       nmag;
  logic [STEP_W:0]   trial;
  logic [DW+1:0]     tsum;
  logic [DW+1:0]     tmag;
  logic [DW:0]       dsat, fsat;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd.op)
      OP_MUL_EDT: begin
        mul_a   = MW'(mag_of(e_r));
        mul_b   = MW'(dt_r);
        mul_neg = e_r[DW-1];
      end
      OP_MUL_P: begin
        mul_a   = MW'(mag_of(kp_r));
        mul_b   = MW'(mag_of(e_r));
        mul_neg = kp_r[DW-1] ^ e_r[DW-1];
      end
      OP_MUL_I: begin
        mul_a   = MW'(mag_of(ki_r));
        mul_b   = MW'(mag_of(integral_r));
        mul_neg = ki_r[DW-1] ^ integral_r[DW-1];
      end
      OP_MUL_D: begin
        mul_a   = MW'(mag_of(kd_r));
        mul_b   = MW'(mag_of(deriv_r));
        mul_neg = kd_r[DW-1] ^ deriv_r[DW-1];
      end
      default: ;
    endcase
  end

  assign shifted = prod_dt_r ? (prod_r >> DT_FRAC_BITS) : (prod_r >> Q_FRAC);
  assign term    = sat_mag(SW'(shifted), prod_neg_r);

  assign isum    = {integral_r[DW-1], integral_r} + {term[DW-1], term[DW-1:0]};
  assign lim_pos = {2'b00, limit_r};
  assign lim_neg = ~lim_pos + (DW+1)'(1);
  assign num     = {e_r[DW-1], e_r} - {last_r[DW-1], last_r};
  assign nmag    = num[DW] ? (~num + (DW+1)'(1)) : num;
  assign trial   = {rem_r, q_r[NW-1]};
  assign dsat    = sat_mag(SW'(q_r), dneg_r);
  assign tsum    = {{2{tp_r[DW-1]}}, tp_r} + {{2{ti_r[DW-1]}}, ti_r}
                 + {{2{td_r[DW-1]}}, td_r};
  assign tmag    = tsum[DW+1] ? (~tsum + (DW+2)'(1)) : tsum;
  assign fsat    = sat_mag(SW'(tmag), tsum[DW+1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      limit_r     <= '1;
      integral_r  <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      flag_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KP:    kp_r <= cfg_wdata;
          REG_KI:    ki_r <= cfg_wdata;
          REG_KD:    kd_r <= cfg_wdata;
          REG_LIMIT: limit_r <= cfg_wdata[DW-2:0];
          default: ;
        endcase
        if (cfg_index != REG_LIMIT) begin
          integral_r <= '0;
          last_r     <= '0;
        end
      end
      if (cmd.load) begin
        e_r    <= error_sample;
        dt_r   <= step_time;
        flag_r <= 1'b0;
      end
      if (cmd.op == OP_MUL_EDT || cmd.op == OP_MUL_P || cmd.op == OP_MUL_I
          || cmd.op == OP_MUL_D) begin
        prod_r     <= PW'(mul_a) * PW'(mul_b);
        prod_neg_r <= mul_neg;
        prod_dt_r  <= (cmd.op == OP_MUL_EDT);
      end
      case (cmd.op)
        OP_INTEG: begin
          flag_r <= flag_r | term[DW];
          if ($signed(isum) > $signed(lim_pos)) integral_r <= lim_pos[DW-1:0];
          else if ($signed(isum) < $signed(lim_neg)) integral_r <= lim_neg[DW-1:0];
          else integral_r <= isum[DW-1:0];
          deriv_r <= '0;
          dneg_r  <= num[DW];
          q_r     <= {nmag, {DT_FRAC_BITS{1'b0}}};
          rem_r   <= '0;
        end
        OP_DIV_STEP: begin
          if (trial >= {1'b0, dt_r}) begin
            rem_r <= STEP_W'(trial - {1'b0, dt_r});
            q_r   <= {q_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= trial[STEP_W-1:0];
            q_r   <= {q_r[NW-2:0], 1'b0};
          end
        end
        OP_DIV_END: begin
          deriv_r <= dsat[DW-1:0];
          flag_r  <= flag_r | dsat[DW];
        end
        OP_MUL_I: begin
          tp_r   <= term[DW-1:0];
          flag_r <= flag_r | term[DW];
        end
        OP_MUL_D: begin
          ti_r   <= term[DW-1:0];
          flag_r <= flag_r | term[DW];
        end
        OP_TERM_D: begin
          td_r   <= term[DW-1:0];
          flag_r <= flag_r | term[DW];
        end
        OP_FINISH: begin
          drive_r     <= fsat[DW-1:0];
          sat_r       <= flag_r | fsat[DW];
          out_valid_r <= 1'b1;
          last_r      <= e_r;
        end
        default: ;
      endcase
    end
  end

  assign status.dt_zero  = (dt_r == '0);
  assign status.out_busy = out_valid_r;
  assign drive     = drive_r;
  assign saturated = sat_r;
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/pidaw_ctrl.sv
// Controller state machine of the PID controller, sequencing the shared datapath.
// Depends on pidaw_pkg for the command and status types.
`timescale 1ns / 1ps

module pidaw_ctrl #(
  parameter int DIV_STEPS = 57
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output pidaw_pkg::dp_cmd_t    cmd,
  input  pidaw_pkg::dp_status_t status
);
  import pidaw_pkg::*;

  localparam int CW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MEDT, S_INTEG, S_DIV, S_DEND, S_MP, S_MI, S_MD, S_TD, S_FIN
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;

  assign in_ready = rst_n && (state_r == S_IDLE);

  always_comb begin
    cmd.load = in_valid && (state_r == S_IDLE);
    cmd.op   = OP_NOP;
    unique case (state_r)
      S_MEDT:  cmd.op = OP_MUL_EDT;
      S_INTEG: cmd.op = OP_INTEG;
      S_DIV:   cmd.op = OP_DIV_STEP;
      S_DEND:  cmd.op = OP_DIV_END;
      S_MP:    cmd.op = OP_MUL_P;
      S_MI:    cmd.op = OP_MUL_I;
      S_MD:    cmd.op = OP_MUL_D;
      S_TD:    cmd.op = OP_TERM_D;
      S_FIN:   cmd.op = status.out_busy ? OP_NOP : OP_FINISH;
      default: cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE:  if (in_valid) state_r <= S_MEDT;
        S_MEDT:  state_r <= S_INTEG;
        S_INTEG: begin
          cnt_r   <= '0;
          state_r <= status.dt_zero ? S_MP : S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(DIV_STEPS - 1)) state_r <= S_DEND;
        end
        S_DEND:  state_r <= S_MP;
        S_MP:    state_r <= S_MI;
        S_MI:    state_r <= S_MD;
        S_MD:    state_r <= S_TD;
        S_TD:    state_r <= S_FIN;
        S_FIN:   if (!status.out_busy) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: verif/pid_controller_antiwindup_checker.sv
// Checker for the PID controller with integral clamp: watches the input, result and register
// ports, predicts each result in fixed point, and counts mismatches.
// Depends on pidaw_pkg for the register index codes and the STEP_W and Q_FRAC constants.
`timescale 1ns / 1ps

module pid_controller_antiwindup_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          pending,
  output int          fail_count
);
  import pidaw_pkg::*;

  localparam longint MAX_V = 64'sh7FFF_FFFF;
  localparam longint MIN_V = -64'sh8000_0000;

  typedef struct {
    logic [31:0] drive;
    logic        saturated;
  } pid_result_t;

  pid_result_t expected_q[$];
  longint      gain_p, gain_i, gain_d, limit_v, integ_acc, prev_err;

  function automatic longint clip(longint v, inout bit flag);
    if (v > MAX_V) begin
      flag = 1;
      return MAX_V;
    end
    if (v < MIN_V) begin
      flag = 1;
      return MIN_V;
    end
    return v;
  endfunction

  function automatic longint mul_trunc(longint a, longint b, int sh, inout bit flag);
    bit              neg;
    longint unsigned mag;
    neg = (a < 0) != (b < 0);
    mag = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
    mag = mag >> sh;
    if (mag == 0) neg = 0;
    return clip(neg ? -longint'(mag) : longint'(mag), flag);
  endfunction

  function automatic longint rate_of(longint num, longint unsigned den, inout bit flag);
    longint unsigned q;
    q = (longint'(num < 0 ? -num : num) << STEP_W) / den;
    return clip((num < 0) ? -longint'(q) : longint'(q), flag);
  endfunction

  function automatic pid_result_t control_step(longint err, longint unsigned dt);
    pid_result_t r;
    bit          flag;
    longint      acc, slope, tp, ti, td;
    flag = 0;
    slope = 0;
    acc = integ_acc + mul_trunc(err, longint'(dt), STEP_W, flag);
    if (acc > limit_v) acc = limit_v;
    if (acc < -limit_v) acc = -limit_v;
    integ_acc = acc;
    if (dt > 0) slope = rate_of(err - prev_err, dt, flag);
    tp = mul_trunc(gain_p, err, Q_FRAC, flag);
    ti = mul_trunc(gain_i, integ_acc, Q_FRAC, flag);
    td = mul_trunc(gain_d, slope, Q_FRAC, flag);
    r.drive = 32'(clip(tp + ti + td, flag));
    r.saturated = flag;
    prev_err = err;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pid_result_t w;
    if (!rst_n) begin
      gain_p = 0;
      gain_i = 0;
      gain_d = 0;
      limit_v = MAX_V;
      integ_acc = 0;
      prev_err = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", out_tdata, 0);
        end else begin
          w = expected_q.pop_front();
          if (out_tdata !== w.drive) report("drive", out_tdata, w.drive);
          if (out_tuser !== w.saturated) report("saturated", out_tuser, w.saturated);
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(control_step(longint'($signed(in_tdata[31:0])),
                                          longint'(in_tdata[55:32])));
      if (cfg_we) begin
        case (cfg_index)
          REG_KP: gain_p = longint'($signed(cfg_wdata));
          REG_KI: gain_i = longint'($signed(cfg_wdata));
          REG_KD: gain_d = longint'($signed(cfg_wdata));
          default: limit_v = longint'(cfg_wdata[30:0]);
        endcase
        if (cfg_index != REG_LIMIT) begin
          integ_acc = 0;
          prev_err = 0;
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

FILE: verif/pid_controller_antiwindup_top_test.sv
// Testbench top for the PID controller with integral clamp: clock, reset, register phases,
// directed and random error/time-step beats, and the verdict.
// Depends on pidaw_pkg, the block and pid_controller_antiwindup_checker.
`timescale 1ns / 1ps

module pid_controller_antiwindup_top_test;
  import pidaw_pkg::*;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [55:0] in_tdata;
  logic [31:0] out_tdata, cfg_wdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  int          pending, fail_count, quiet_cycles;
  bit          calm;

  pid_controller_antiwindup_top u_dut (.*);

  pid_controller_antiwindup_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 9);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_sample(logic [31:0] err, logic [23:0] dt);
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {dt, err};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    in_tvalid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (80) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] pick_err();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000);
    endcase
  endfunction

  function automatic logic [23:0] pick_dt();
    case ($urandom_range(4))
      0: return 24'd0;
      1: return 24'($urandom_range(1, 255));
      2: return 24'($urandom);
      default: return 24'($urandom_range(24'h100, 24'h40000));
    endcase
  endfunction

  logic [31:0] gains[6][4];

  initial begin
    in_tvalid = 0;
    in_tdata = 0;
    cfg_we = 0;
    cfg_index = REG_KP;
    cfg_wdata = 0;
    calm = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    gains = '{'{32'h0001_0000, 32'h0000_8000, 32'h0000_1000, 32'h0100_0000},
              '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
              '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000},
              '{32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_FFFF, 32'h0001_0000},
              '{32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001},
              '{32'h0003_4000, 32'hFFFE_8000, 32'h0000_0400, 32'h0050_0000}};
    // Beats under reset values of the registers first.
    send_sample(32'h7FFF_FFFF, 24'hFFFFFF);
    send_sample(32'h8000_0000, 24'h000001);
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 2);
      for (int r = 0; r < 4; r++) write_reg(r[1:0], gains[ph][r]);
      if (ph == 0) begin
        send_sample(32'h0001_0000, 24'h000000);
        send_sample(32'h0001_0000, 24'h800000);
        send_sample(32'h7FFF_FFFF, 24'hFFFFFF);
        send_sample(32'h7FFF_FFFF, 24'hFFFFFF);
        send_sample(32'h8000_0000, 24'h000001);
        send_sample(32'h7FFF_FFFF, 24'h000001);
        send_sample(32'h0000_0000, 24'h000000);
        send_sample(32'hFFFF_FFFF, 24'h000001);
        send_sample(32'h0000_0001, 24'hFFFFFF);
        send_sample(32'h8000_0000, 24'hFFFFFF);
        send_sample(32'h8000_0000, 24'hFFFFFF);
        send_sample(32'h0100_0000, 24'h000010);
        send_sample(32'hFF00_0000, 24'h000000);
      end
      for (int k = 0; k < 130; k++) send_sample(pick_err(), pick_dt());
    end
    in_tvalid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
